@@ src/pfdt_pkg.sv @@
package pfdt_pkg;

    // Field widths of the stream items.
    localparam int COUNT_WIDTH = 32;
    localparam int WORD_WIDTH  = 32;
    localparam int TEXT_DIGITS = 10;
    localparam int HEAD_WIDTH  = 64;
    localparam int TAIL_WIDTH  = 24;

    // Dividend is ref_clock_hz * 1000, which always fits in 42 bits.
    localparam int DVD_WIDTH   = 42;
    localparam int BCD_WIDTH   = 4 * TEXT_DIGITS;

    // Constants of the conversion.
    localparam logic [9:0]            MILLI_SCALE = 10'd1000;
    localparam logic [WORD_WIDTH-1:0] SAT_VALUE   = '1;
    localparam logic [WORD_WIDTH-1:0] REF_RESET   = 32'd200000000;
    localparam logic [7:0]            ASCII_ZERO  = 8'h30;
    localparam logic [7:0]            ASCII_POINT = 8'h2E;

    // Queue depth between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // One report request passed from the front to the back.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
    } t_job;

    // Handshake between queue and back end.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_chan;

endpackage

@@ src/pfdt_front.sv @@
module pfdt_front
    import pfdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [WORD_WIDTH-1:0] i_count,
    input  logic [WORD_WIDTH-1:0] i_status,
    input  logic                  i_queue_full,
    output logic                  o_ready,
    output logic                  o_push,
    output t_job                  o_job
);

    logic                  r_primed;
    logic [WORD_WIDTH-1:0] r_last_status;
    logic                  w_accept;

    // The front accepts whenever the queue has room for a possible report.
    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;

    // A changed status after the first transaction requests a report.
    assign o_push    = w_accept && r_primed && (i_status != r_last_status);
    assign o_job.count = i_count[COUNT_WIDTH-1:0];

    // Track the most recent status word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed      <= 1'b0;
            r_last_status <= '0;
        end else if (w_accept) begin
            r_primed      <= 1'b1;
            r_last_status <= i_status;
        end
    end

endmodule

@@ src/pfdt_fifo.sv @@
module pfdt_fifo
    import pfdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output logic      o_full,
    output t_job_chan o_head
);

    t_job                  r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count;
    logic                  w_pop;

    assign o_full       = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && o_head.valid;

    // Storage of queued requests.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/pfdt_back.sv @@
module pfdt_back
    import pfdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [WORD_WIDTH-1:0] i_ref_clock_hz,
    input  t_job_chan             i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [WORD_WIDTH-1:0] o_measured_count,
    output logic [WORD_WIDTH-1:0] o_freq_millihertz,
    output logic [HEAD_WIDTH-1:0] o_text_head,
    output logic [TAIL_WIDTH-1:0] o_text_tail,
    output logic                  o_saturated
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_BCD  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;

    localparam int DCNT_WIDTH = $clog2(DVD_WIDTH);
    localparam int BCNT_WIDTH = $clog2(WORD_WIDTH);

    logic [2:0]             r_state;
    logic [DCNT_WIDTH-1:0]  r_div_cnt;
    logic [BCNT_WIDTH-1:0]  r_bcd_cnt;
    logic [COUNT_WIDTH-1:0] r_divisor;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [DVD_WIDTH-1:0]   r_dvd;
    logic [WORD_WIDTH-1:0]  r_freq;
    logic [WORD_WIDTH-1:0]  r_bin;
    logic [BCD_WIDTH-1:0]   r_bcd;
    logic                   r_sat;

    logic                   r_out_valid;
    logic [WORD_WIDTH-1:0]  r_out_count;
    logic [WORD_WIDTH-1:0]  r_out_freq;
    logic [HEAD_WIDTH-1:0]  r_out_head;
    logic [TAIL_WIDTH-1:0]  r_out_tail;
    logic                   r_out_sat;

    logic [COUNT_WIDTH:0]   w_rem_sh;
    logic                   w_qbit;
    logic [COUNT_WIDTH-1:0] n_rem;
    logic [BCD_WIDTH-1:0]   w_bcd_adj;
    logic [HEAD_WIDTH-1:0]  w_head;
    logic [TAIL_WIDTH-1:0]  w_tail;
    logic                   w_load;
    logic [WORD_WIDTH-1:0]  w_quot_lo;

    assign o_pop = (r_state == ST_IDLE) && i_head.valid;
    assign w_load = (r_state == ST_LOAD) && (!r_out_valid || i_ready);

    // One restoring division step: shift in the next dividend bit, then try to subtract.
    always_comb begin
        w_rem_sh = {r_rem, r_dvd[DVD_WIDTH-1]};
        w_qbit   = (w_rem_sh >= {1'b0, r_divisor});
        if (w_qbit) begin
            n_rem = COUNT_WIDTH'(w_rem_sh - {1'b0, r_divisor});
        end else begin
            n_rem = w_rem_sh[COUNT_WIDTH-1:0];
        end
    end

    // Low word of the finished quotient; the last step's bit is still on its way in.
    assign w_quot_lo = {r_dvd[WORD_WIDTH-2:0], w_qbit};

    // Double-dabble correction: add three to every digit of five or more.
    always_comb begin
        for (int i = 0; i < TEXT_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // ASCII text: seven integer digits and a point, then three fractional digits.
    always_comb begin
        w_head = '0;
        w_tail = '0;
        for (int i = 0; i < 7; i++) begin
            w_head[HEAD_WIDTH-1-8*i -: 8] = ASCII_ZERO | {4'd0, r_bcd[BCD_WIDTH-1-4*i -: 4]};
        end
        w_head[7:0] = ASCII_POINT;
        for (int i = 0; i < 3; i++) begin
            w_tail[TAIL_WIDTH-1-8*i -: 8] = ASCII_ZERO | {4'd0, r_bcd[11-4*i -: 4]};
        end
    end

    // Sequencer: division (skipped for a zero count), then binary to decimal, then hand-off to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_divisor <= i_head.job.count;
                        r_rem     <= '0;
                        r_dvd     <= {{(DVD_WIDTH-WORD_WIDTH){1'b0}}, i_ref_clock_hz}
                                     * {{(DVD_WIDTH-10){1'b0}}, MILLI_SCALE};
                        r_div_cnt <= DCNT_WIDTH'(DVD_WIDTH - 1);
                        if (i_head.job.count == '0) begin
                            // A zero count saturates without dividing.
                            r_freq    <= SAT_VALUE;
                            r_sat     <= 1'b1;
                            r_bin     <= SAT_VALUE;
                            r_bcd     <= '0;
                            r_bcd_cnt <= BCNT_WIDTH'(WORD_WIDTH - 1);
                            r_state   <= ST_BCD;
                        end else begin
                            r_state   <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem     <= n_rem;
                    r_dvd     <= {r_dvd[DVD_WIDTH-2:0], w_qbit};
                    r_div_cnt <= r_div_cnt - 1'b1;
                    if (r_div_cnt == '0) begin
                        // Quotient bits above the word width mean saturation.
                        if (r_dvd[DVD_WIDTH-2:WORD_WIDTH-1] != '0) begin
                            r_freq <= SAT_VALUE;
                            r_sat  <= 1'b1;
                            r_bin  <= SAT_VALUE;
                        end else begin
                            r_freq <= w_quot_lo;
                            r_sat  <= 1'b0;
                            r_bin  <= w_quot_lo;
                        end
                        r_bcd     <= '0;
                        r_bcd_cnt <= BCNT_WIDTH'(WORD_WIDTH - 1);
                        r_state   <= ST_BCD;
                    end
                end
                ST_BCD: begin
                    r_bcd     <= {w_bcd_adj[BCD_WIDTH-2:0], r_bin[WORD_WIDTH-1]};
                    r_bin     <= {r_bin[WORD_WIDTH-2:0], 1'b0};
                    r_bcd_cnt <= r_bcd_cnt - 1'b1;
                    if (r_bcd_cnt == '0) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: holds a finished report until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_count <= WORD_WIDTH'(r_divisor);
            r_out_freq  <= r_freq;
            r_out_head  <= w_head;
            r_out_tail  <= w_tail;
            r_out_sat   <= r_sat;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_measured_count  = r_out_count;
    assign o_freq_millihertz = r_out_freq;
    assign o_text_head       = r_out_head;
    assign o_text_tail       = r_out_tail;
    assign o_saturated       = r_out_sat;

endmodule

@@ src/period_to_frequency_decimal_text.sv @@
// A report is offered once the back end has taken the request from the queue, run the
// division and the binary to decimal steps and loaded the output register; a zero count
// skips the division. The bit-serial back end takes no new request until the last report is loaded;
// transactions with an unchanged status are taken every cycle while the 2-entry queue has room.
// Reset (synchronous, active low) empties the queue and output, clears the stored status,
// and sets the reference clock register to 200000000 Hz.
module period_to_frequency_decimal_text
    import pfdt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration: reference clock in hertz.
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    // Input stream.
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [63:0]   i_s_axis_tdata,  // [31:0] period_count, [63:32] status_word
    // Output stream.
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [31:0] measured_count, [63:32] freq_millihertz, [127:64] text_head,
    // [151:128] text_tail
    output logic [151:0]  o_m_axis_tdata,
    output logic          o_m_axis_tuser   // [0] saturated
);

    logic [WORD_WIDTH-1:0] r_ref_clock_hz;
    logic                  w_queue_full;
    logic                  w_push;
    logic                  w_pop;
    t_job                  w_job;
    t_job_chan             w_head;
    logic [WORD_WIDTH-1:0] w_count;
    logic [WORD_WIDTH-1:0] w_freq;
    logic [HEAD_WIDTH-1:0] w_text_head;
    logic [TAIL_WIDTH-1:0] w_text_tail;

    // Reference clock register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock_hz <= REF_RESET;
        end else if (i_cfg_wr_en) begin
            r_ref_clock_hz <= i_cfg_wr_data;
        end
    end

    pfdt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_count      (i_s_axis_tdata[31:0]),
        .i_status     (i_s_axis_tdata[63:32]),
        .i_queue_full (w_queue_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (w_push),
        .o_job        (w_job)
    );

    pfdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_queue_full),
        .o_head  (w_head)
    );

    pfdt_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ref_clock_hz    (r_ref_clock_hz),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_measured_count  (w_count),
        .o_freq_millihertz (w_freq),
        .o_text_head       (w_text_head),
        .o_text_tail       (w_text_tail),
        .o_saturated       (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {w_text_tail, w_text_head, w_freq, w_count};

endmodule
